// File: rtl/core/assert_macros.svh
// Assertion macros used by the RTL files (ts_packet_masked_compare).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/core/tspmc_pkg.sv
// Package: constants, types and header helpers of the TS packet comparator.
package tspmc_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int BYTE_W       = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 8;

    localparam logic [12:0] NULL_PID = 13'h1FFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_ONLY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_PCR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_PID     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CC      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 3'd4;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETUP,
        ST_COMPARE,
        ST_DONE
    } t_state;

    // per-packet masking flags
    typedef struct packed {
        logic z6;
        logic z12;
    } t_clk_mask;

    function automatic logic [BYTE_W-1:0] hdr_size(input logic [7:0] b3, input logic [7:0] b4,
                                                   input int pkt_bytes);
        logic [8:0] raw;
        raw = 9'd4 + (b3[5] ? (9'd1 + {1'b0, b4}) : 9'd0);
        return (raw > 9'(pkt_bytes)) ? BYTE_W'(pkt_bytes) : raw[BYTE_W-1:0];
    endfunction

    function automatic logic [BYTE_W-1:0] pay_size(input logic [7:0] b3, input logic [7:0] b4,
                                                   input int pkt_bytes);
        return b3[4] ? (BYTE_W'(pkt_bytes) - hdr_size(b3, b4, pkt_bytes)) : '0;
    endfunction

    function automatic t_clk_mask clk_mask(input logic ign_pcr, input logic [7:0] b3,
                                           input logic [7:0] b4, input logic [7:0] b5);
        t_clk_mask m;
        m.z6  = ign_pcr && b3[5] && (b4 >= 8'd7) && (b5[4] || b5[3]);
        m.z12 = ign_pcr && b3[5] && (b4 >= 8'd13) && b5[4] && b5[3];
        return m;
    endfunction

    function automatic logic [7:0] mask_byte(input logic [7:0] b, input logic [7:0] off,
                                             input logic en, input logic ign_pid,
                                             input logic ign_cc, input t_clk_mask m);
        logic [7:0] r;
        r = b;
        if (en) begin
            if (m.z6 && off >= 8'd6 && off <= 8'd11) begin
                r = (off == 8'd10) ? 8'h7E : 8'h00;
            end
            if (m.z12 && off >= 8'd12 && off <= 8'd17) begin
                r = (off == 8'd16) ? 8'h7E : 8'h00;
            end
            if (ign_pid && off == 8'd1) begin
                r = r | 8'h1F;
            end
            if (ign_pid && off == 8'd2) begin
                r = 8'hFF;
            end
            if (ign_cc && off == 8'd3) begin
                r = r & 8'hF0;
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/core/tspmc_if.sv
// Request channel interfaces: byte pair input, result output, register writes.
interface tspmc_in_if;
    import tspmc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_first;
    logic [BYTE_W-1:0] byte_second;
    logic              last_byte;
    modport source (output valid, byte_first, byte_second, last_byte, input ready);
    modport sink   (input valid, byte_first, byte_second, last_byte, output ready);
endinterface

interface tspmc_out_if;
    import tspmc_pkg::*;
    logic              valid;
    logic              ready;
    logic              packets_equal;
    logic [BYTE_W-1:0] cmp_len;
    logic [BYTE_W-1:0] first_off;
    logic [BYTE_W-1:0] end_off;
    logic [BYTE_W-1:0] diff_total;
    modport source (output valid, packets_equal, cmp_len, first_off, end_off,
                    diff_total, input ready);
    modport sink   (input valid, packets_equal, cmp_len, first_off, end_off,
                    diff_total, output ready);
endinterface

interface tspmc_cfg_if;
    import tspmc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/ts_packet_masked_compare.sv
// Top level: masked byte comparison of two MPEG transport stream packets.
//
// i_in carries one byte pair per request, starting at the sync byte; last_byte
// marks the final pair. Pairs beyond PACKET_BYTES are dropped until last_byte.
// On last_byte the block stops taking requests: a setup state decodes the
// headers, then the single byte comparator walks the compared region, one
// pair a cycle from the two byte stores (registered read ports).
// A pair without last_byte is taken whenever the block is loading. The
// compared size is 188 in full-packet mode and 0..184 in payload mode.
// The result sits in an output register on o_out; loading the next packet
// goes on while it waits. While the receiver stalls, the next result waits
// in the final state and no request is taken until the output register frees.
// i_cfg writes registers (0 payload-only mode .. 4 diff_threshold); it is
// always ready and must only be used while the block is idle.
// Reset clears the registers, the load position and all handshake state;
// the byte stores are not cleared.
`include "assert_macros.svh"
module ts_packet_masked_compare #(
    parameter int P_PACKET_BYTES = tspmc_pkg::PACKET_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tspmc_in_if.sink            i_in,
    tspmc_cfg_if.sink           i_cfg,
    tspmc_out_if.source         o_out
);
    import tspmc_pkg::*;

    localparam int AW  = $clog2(P_PACKET_BYTES);
    localparam int LPW = $clog2(P_PACKET_BYTES + 1);

    t_state r_state, n_state;

    logic              r_pay_only, r_ignore_pcr, r_ignore_pid, r_ignore_cc;
    logic [BYTE_W-1:0] r_diff_threshold;

    logic [LPW-1:0]    r_load_pos;
    logic [7:0]        r_hdr_a [1:5];
    logic [7:0]        r_hdr_b [1:5];

    logic [AW-1:0]     r_start_a, r_start_b;
    logic [LPW-1:0]    r_n, r_idx;
    logic              r_null, r_both_null, r_size_eq, r_mask_en;
    t_clk_mask         r_cm_a, r_cm_b;

    logic              r_cmp_vld;
    logic [AW-1:0]     r_cmp_idx;
    logic              r_found;
    logic [BYTE_W-1:0] r_cnt, r_first, r_end;

    logic              r_out_valid, r_out_equal;
    logic [BYTE_W-1:0] r_out_size, r_out_first, r_out_end, r_out_cnt;

    logic              in_fire, we, re, out_load, last_fire;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic [7:0]        rd_a, rd_b, ma, mb;

    // header decode for setup
    logic [12:0]       pid_a, pid_b;
    logic              null_a, null_b, pay_mode;
    logic [BYTE_W-1:0] ps_a, ps_b;

    assign in_fire   = i_in.valid && i_in.ready;
    assign last_fire = in_fire && i_in.last_byte;
    assign we        = in_fire && (r_load_pos < LPW'(P_PACKET_BYTES));

    assign pid_a    = {r_hdr_a[1][4:0], r_hdr_a[2]};
    assign pid_b    = {r_hdr_b[1][4:0], r_hdr_b[2]};
    assign null_a   = (pid_a == NULL_PID);
    assign null_b   = (pid_b == NULL_PID);
    assign pay_mode = r_pay_only && !null_a && !null_b;
    assign ps_a     = pay_size(r_hdr_a[3], r_hdr_a[4], P_PACKET_BYTES);
    assign ps_b     = pay_size(r_hdr_b[3], r_hdr_b[4], P_PACKET_BYTES);

    tspmc_ram #(.DEPTH(P_PACKET_BYTES), .WIDTH(BYTE_W)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_load_pos[AW-1:0]),
        .i_wdata (i_in.byte_first),
        .i_re    (re),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    tspmc_ram #(.DEPTH(P_PACKET_BYTES), .WIDTH(BYTE_W)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_load_pos[AW-1:0]),
        .i_wdata (i_in.byte_second),
        .i_re    (re),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (last_fire) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP:   n_state = ST_COMPARE;
            ST_COMPARE: begin
                if (r_idx == r_n) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        re         = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            ST_LOAD:    i_in.ready = 1'b1;
            ST_SETUP:   ;
            ST_COMPARE: re = (r_idx < r_n);
            ST_DONE:    out_load = !r_out_valid || o_out.ready;
            default:    ;
        endcase
    end

    assign raddr_a = AW'(r_start_a + r_idx[AW-1:0]);
    assign raddr_b = AW'(r_start_b + r_idx[AW-1:0]);

    assign ma = mask_byte(rd_a, BYTE_W'(r_cmp_idx), r_mask_en, r_ignore_pid, r_ignore_cc,
                          r_cm_a);
    assign mb = mask_byte(rd_b, BYTE_W'(r_cmp_idx), r_mask_en, r_ignore_pid, r_ignore_cc,
                          r_cm_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_LOAD;
            r_load_pos       <= '0;
            r_pay_only       <= 1'b0;
            r_ignore_pcr     <= 1'b0;
            r_ignore_pid     <= 1'b0;
            r_ignore_cc      <= 1'b0;
            r_diff_threshold <= '0;
            r_cmp_vld        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= re;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_PAYLOAD_ONLY:   r_pay_only       <= i_cfg.data[0];
                    CFG_IGNORE_PCR:     r_ignore_pcr     <= i_cfg.data[0];
                    CFG_IGNORE_PID:     r_ignore_pid     <= i_cfg.data[0];
                    CFG_IGNORE_CC:      r_ignore_cc      <= i_cfg.data[0];
                    CFG_DIFF_THRESHOLD: r_diff_threshold <= i_cfg.data;
                    default:            ;
                endcase
            end
            if (last_fire) begin
                r_load_pos <= '0;
            end else if (we) begin
                r_load_pos <= r_load_pos + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_cfg.ready = 1'b1;

    // header capture, setup, compare accumulation, result register
    always_ff @(posedge i_clk) begin
        if (we) begin
            for (int k = 1; k <= 5; k++) begin
                if (r_load_pos == LPW'(k)) begin
                    r_hdr_a[k] <= i_in.byte_first;
                    r_hdr_b[k] <= i_in.byte_second;
                end
            end
        end
        if (r_state == ST_SETUP) begin
            r_null      <= null_a || null_b;
            r_both_null <= null_a && null_b;
            r_mask_en   <= !null_a && !null_b && !r_pay_only;
            r_cm_a      <= clk_mask(r_ignore_pcr, r_hdr_a[3], r_hdr_a[4], r_hdr_a[5]);
            r_cm_b      <= clk_mask(r_ignore_pcr, r_hdr_b[3], r_hdr_b[4], r_hdr_b[5]);
            r_idx       <= '0;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            if (pay_mode) begin
                r_start_a <= AW'(hdr_size(r_hdr_a[3], r_hdr_a[4], P_PACKET_BYTES));
                r_start_b <= AW'(hdr_size(r_hdr_b[3], r_hdr_b[4], P_PACKET_BYTES));
                r_n       <= LPW'((ps_a < ps_b) ? ps_a : ps_b);
                r_first   <= (ps_a < ps_b) ? ps_a : ps_b;
                r_end     <= (ps_a < ps_b) ? ps_a : ps_b;
                r_size_eq <= (ps_a == ps_b);
            end else begin
                r_start_a <= '0;
                r_start_b <= '0;
                r_n       <= LPW'(P_PACKET_BYTES);
                r_first   <= BYTE_W'(P_PACKET_BYTES);
                r_end     <= BYTE_W'(P_PACKET_BYTES);
                r_size_eq <= 1'b1;
            end
        end
        if (re) begin
            r_idx     <= r_idx + 1'b1;
        end
        r_cmp_idx <= r_idx[AW-1:0];
        if (r_cmp_vld && (ma != mb)) begin
            r_cnt <= r_cnt + 1'b1;
            r_end <= BYTE_W'({1'b0, r_cmp_idx} + 1'b1);
            if (!r_found) begin
                r_found <= 1'b1;
                r_first <= BYTE_W'(r_cmp_idx);
            end
        end
        if (out_load) begin
            r_out_equal <= r_null ? r_both_null
                                  : ((r_cnt <= r_diff_threshold) && r_size_eq);
            r_out_size  <= BYTE_W'(r_n);
            r_out_first <= r_first;
            r_out_end   <= r_end;
            r_out_cnt   <= r_cnt;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.packets_equal = r_out_equal;
    assign o_out.cmp_len       = r_out_size;
    assign o_out.first_off     = r_out_first;
    assign o_out.end_off       = r_out_end;
    assign o_out.diff_total    = r_out_cnt;

    `ASSERT_NEXT(a_last_starts_setup, i_clk, i_rst_n, last_fire, r_state == ST_SETUP,
                 "last pair did not start setup")
    `ASSERT_PROP(a_idx_in_range, i_clk, i_rst_n, (r_state == ST_COMPARE) |-> (r_idx <= r_n),
                 "compare index ran past region")
    `ASSERT_PROP(a_cmp_in_compare, i_clk, i_rst_n, r_cmp_vld |-> (r_state == ST_COMPARE),
                 "compare data outside compare phase")
    `ASSERT_PROP(a_first_before_end, i_clk, i_rst_n,
                 ((r_state == ST_DONE) && (r_cnt != '0)) |-> (r_first < r_end),
                 "first difference not before end")
    `ASSERT_PROP(a_count_bounded, i_clk, i_rst_n, (r_state == ST_DONE) |-> (LPW'(r_cnt) <= r_n),
                 "difference count exceeds compared size")
endmodule

// File: rtl/core/tspmc_ram.sv
// Packet byte store: one write port, one registered read port.
module tspmc_ram #(
    parameter int DEPTH = tspmc_pkg::PACKET_BYTES,
    parameter int WIDTH = tspmc_pkg::BYTE_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
